### rtl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define RDS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rds assertion failed");

// next-cycle implication
`define RDS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rds assertion failed");

`endif

### rtl/rds_pkg.sv
// ----------------------------------------------------------------------------
// rds_pkg
// Types, widths and constants of the reaction-diffusion stencil update block.
// ----------------------------------------------------------------------------
`default_nettype none

package rds_pkg;

  localparam int BLOCK_EDGE  = 16;
  localparam int PADDED      = BLOCK_EDGE + 2;
  localparam int PLANE       = PADDED * PADDED;
  localparam int STORE_DEPTH = 2 * PLANE;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int POS_W       = $clog2(PADDED);

  localparam int FIELD_W   = 16;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int RATE_W    = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WHITE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GREY  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RHO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IH2   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DT    = 3'd4;

  localparam int TINY_DIFF   = 3;
  localparam int EMPTY_LIMIT = 3277;
  localparam int ONE_Q15     = 32768;

  localparam int DIFF_W    = 34;   // cell diffusivity
  localparam int SUM_W     = 35;   // face diffusivity sum
  localparam int REM_W     = 36;   // divider remainder
  localparam int Q_W       = 31;   // quotient
  localparam int FACE_W    = 36;
  localparam int ACC_W     = 58;
  localparam int DCNT_W    = 5;
  localparam int DIV_STEPS = 31;

  // entry slots: centre, five stored neighbours, incoming word
  localparam int NSLOT  = 6;
  localparam int NENT   = 7;
  localparam int NFACE  = 6;
  localparam int SLOT_W = 3;

  typedef struct packed {
    logic [FIELD_W-1:0] grey;
    logic [FIELD_W-1:0] white;
    logic [FIELD_W-1:0] phi;
  } cell_t;

  localparam int CELL_W = $bits(cell_t);

  typedef struct packed {
    logic latch;
    logic rd_issue;
    logic wr_cur;
    logic cd_mul;
    logic cd_fin;
    logic cd_ctr;
    logic div_step;
    logic face_zero;
    logic face_mul;
    logic acc;
    logic dif_a;
    logic dif_b;
    logic rate_sum;
    logic rate_zero;
    logic up_a;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic rd_last;
    logic nomat;
    logic tiny;
    logic div_last;
    logic face_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

### rtl/rds_in_if.sv
// ----------------------------------------------------------------------------
// rds_in_if
// Input channel: one padded cell per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface rds_in_if import rds_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] concentration;
  logic [FIELD_W-1:0] white_fraction;
  logic [FIELD_W-1:0] grey_fraction;

  modport source (output valid, output concentration, output white_fraction,
                  output grey_fraction, input ready);
  modport sink (input valid, input concentration, input white_fraction,
                input grey_fraction, output ready);
endinterface

`default_nettype wire

### rtl/rds_out_if.sv
// ----------------------------------------------------------------------------
// rds_out_if
// Result channel: derivative, updated density and end-of-block flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface rds_out_if import rds_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [RATE_W-1:0] rate_of_change;
  logic [FIELD_W-1:0]       updated_concentration;
  logic                     block_done;

  modport source (output valid, output rate_of_change,
                  output updated_concentration, output block_done, input ready);
  modport sink (input valid, input rate_of_change, input updated_concentration,
                input block_done, output ready);
endinterface

`default_nettype wire

### rtl/rds_ram.sv
// ----------------------------------------------------------------------------
// rds_ram
// Generic simple dual-port ram, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/rds_ctrl.sv
// ----------------------------------------------------------------------------
// rds_ctrl
// Sequencer: plane reads, six face passes with divider, reaction and update.
// ----------------------------------------------------------------------------
`default_nettype none

module rds_ctrl import rds_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_READ  = 4'd1;
  localparam logic [3:0] S_RWAIT = 4'd2;
  localparam logic [3:0] S_CHECK = 4'd3;
  localparam logic [3:0] S_CDMUL = 4'd4;
  localparam logic [3:0] S_CDFIN = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_FMUL  = 4'd7;
  localparam logic [3:0] S_ACC   = 4'd8;
  localparam logic [3:0] S_DIFA  = 4'd9;
  localparam logic [3:0] S_DIFB  = 4'd10;
  localparam logic [3:0] S_SUM   = 4'd11;
  localparam logic [3:0] S_UPA   = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  logic [3:0] state_r, state_nxt;
  logic       ctr_r, ctr_nxt;   // cell diffusivity pass is for the centre

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ctr_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ctr_r   <= ctr_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctr_nxt   = ctr_r;
    cmd       = '0;
    in_ready  = 1'b0;
    cmd.cd_ctr = ctr_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          if (sts.emit) state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        if (sts.rd_last) state_nxt = S_RWAIT;
      end
      S_RWAIT: begin
        cmd.wr_cur = 1'b1;
        state_nxt  = S_CHECK;
      end
      S_CHECK: begin
        if (sts.nomat) begin
          cmd.rate_zero = 1'b1;
          state_nxt     = S_UPA;
        end else begin
          ctr_nxt   = 1'b1;
          state_nxt = S_CDMUL;
        end
      end
      S_CDMUL: begin
        cmd.cd_mul = 1'b1;
        state_nxt  = S_CDFIN;
      end
      S_CDFIN: begin
        cmd.cd_fin = 1'b1;
        if (ctr_r) begin
          ctr_nxt   = 1'b0;
          state_nxt = S_CDMUL;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.tiny) begin
          cmd.face_zero = 1'b1;
          state_nxt     = S_ACC;
        end else begin
          cmd.div_step = 1'b1;
          if (sts.div_last) state_nxt = S_FMUL;
        end
      end
      S_FMUL: begin
        cmd.face_mul = 1'b1;
        state_nxt    = S_ACC;
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = sts.face_last ? S_DIFA : S_CDMUL;
      end
      S_DIFA: begin
        cmd.dif_a = 1'b1;
        state_nxt = S_DIFB;
      end
      S_DIFB: begin
        cmd.dif_b = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.rate_sum = 1'b1;
        state_nxt    = S_UPA;
      end
      S_UPA: begin
        cmd.up_a  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### rtl/rds_dpath.sv
// ----------------------------------------------------------------------------
// rds_dpath
// Datapath: raster position, plane store, face divider, accumulators, output.
// ----------------------------------------------------------------------------
`default_nettype none

module rds_dpath import rds_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire cell_t                in_cell,
  input  wire cmd_t                 cmd,
  output sts_t                      sts,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output logic signed [RATE_W-1:0]  out_rate,
  output logic [FIELD_W-1:0]        out_upd,
  output logic                      out_done
);

  // configuration
  logic [CFG_W-1:0] white_r, grey_r, rho_r, ih2_r, dt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      white_r <= '0;
      grey_r  <= '0;
      rho_r   <= '0;
      ih2_r   <= '0;
      dt_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WHITE: white_r <= cfg_data;
        REG_GREY:  grey_r  <= cfg_data;
        REG_RHO:   rho_r   <= cfg_data;
        REG_IH2:   ih2_r   <= cfg_data;
        REG_DT:    dt_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // raster position and store pointer
  logic [POS_W-1:0]  cx_r, cy_r, cz_r;
  logic [ADDR_W-1:0] wp_r, base_r;
  logic              last_r;

  localparam logic [POS_W-1:0] POS_HI  = POS_W'(PADDED - 2);
  localparam logic [POS_W-1:0] POS_END = POS_W'(PADDED - 1);

  assign sts.emit = (cx_r >= POS_W'(1)) && (cx_r <= POS_HI) &&
                    (cy_r >= POS_W'(1)) && (cy_r <= POS_HI) && (cz_r >= POS_W'(2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= '0;
      cy_r <= '0;
      cz_r <= '0;
      wp_r <= '0;
    end else if (cmd.latch) begin
      wp_r <= (wp_r == ADDR_W'(STORE_DEPTH - 1)) ? '0 : wp_r + ADDR_W'(1);
      if (cx_r == POS_END) begin
        cx_r <= '0;
        if (cy_r == POS_END) begin
          cy_r <= '0;
          cz_r <= (cz_r == POS_END) ? '0 : cz_r + POS_W'(1);
        end else begin
          cy_r <= cy_r + POS_W'(1);
        end
      end else begin
        cx_r <= cx_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      base_r <= wp_r;
      last_r <= (cx_r == POS_HI) && (cy_r == POS_HI) && (cz_r == POS_END);
    end
  end

  // plane store
  function automatic logic [ADDR_W-1:0] rd_addr(input logic [ADDR_W-1:0] base,
                                                input logic [SLOT_W-1:0] slot);
    logic [ADDR_W:0] off;
    logic [ADDR_W:0] t;
    case (slot)
      3'd0:    off = (ADDR_W+1)'(PLANE);
      3'd1:    off = (ADDR_W+1)'(PLANE + 1);
      3'd2:    off = (ADDR_W+1)'(PLANE - 1);
      3'd3:    off = (ADDR_W+1)'(PLANE + PADDED);
      3'd4:    off = (ADDR_W+1)'(PLANE - PADDED);
      default: off = (ADDR_W+1)'(2 * PLANE);
    endcase
    t = {1'b0, base} + (ADDR_W+1)'(STORE_DEPTH) - off;
    if (t >= (ADDR_W+1)'(STORE_DEPTH)) t = t - (ADDR_W+1)'(STORE_DEPTH);
    return t[ADDR_W-1:0];
  endfunction

  cell_t             ent_r [NENT];
  logic [NFACE-1:0]  emp_r;
  logic [SLOT_W-1:0] rdcnt_r, rdslot_r;
  logic              rdv_r;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  cell_t             ram_wdata;
  logic [CELL_W-1:0] ram_rdata;
  cell_t             rd_cell;

  assign ram_we    = (cmd.latch && !sts.emit) || cmd.wr_cur;
  assign ram_waddr = cmd.wr_cur ? base_r : wp_r;
  assign ram_wdata = cmd.wr_cur ? ent_r[NENT-1] : in_cell;
  assign ram_raddr = rd_addr(base_r, rdcnt_r);
  assign rd_cell   = cell_t'(ram_rdata);
  assign sts.rd_last = (rdcnt_r == SLOT_W'(NSLOT - 1));

  rds_ram #(.WIDTH(CELL_W), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  function automatic logic is_empty(input cell_t c);
    logic [FIELD_W+1:0] s;
    s = {2'b0, c.phi} + {2'b0, c.white} + {2'b0, c.grey};
    return s < (FIELD_W+2)'(EMPTY_LIMIT);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rdv_r   <= 1'b0;
      rdcnt_r <= '0;
    end else begin
      rdv_r <= cmd.rd_issue;
      if (cmd.latch) rdcnt_r <= '0;
      else if (cmd.rd_issue) rdcnt_r <= rdcnt_r + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    rdslot_r <= rdcnt_r;
    if (cmd.latch) begin
      ent_r[NENT-1]   <= in_cell;
      emp_r[NFACE-1]  <= is_empty(in_cell);
    end
    if (rdv_r) begin
      ent_r[rdslot_r] <= rd_cell;
      if (rdslot_r != '0) emp_r[SLOT_W'(rdslot_r - SLOT_W'(1))] <= is_empty(rd_cell);
    end
  end

  logic [FIELD_W-1:0] pc;
  logic [FIELD_W+1:0] ctr_sum;
  assign pc      = ent_r[0].phi;
  assign ctr_sum = {2'b0, ent_r[0].phi} + {2'b0, ent_r[0].white} + {2'b0, ent_r[0].grey};
  assign sts.nomat = (ctr_sum == '0);

  // face loop
  logic [SLOT_W-1:0]      fi_r, nb_idx;
  cell_t                  sel_cell;
  logic [47:0]            pw_r, pg_r;
  logic [48:0]            dsum;
  logic [DIFF_W-1:0]      dnew, dc_r, dn_r;
  logic [SUM_W-1:0]       sum_r;
  logic [REM_W-1:0]       rem_r, rem_sh;
  logic [Q_W-1:0]         q_r;
  logic [DCNT_W-1:0]      dcnt_r;
  logic [FACE_W-1:0]      face_r;
  logic [62:0]            fp_lo;
  logic [32:0]            fp_hi;
  logic [64:0]            fprod;
  logic [FACE_W:0]        face2;
  logic signed [FIELD_W:0] dphi;
  logic signed [54:0]     term;
  logic signed [ACC_W-1:0] acc_r;

  assign nb_idx   = SLOT_W'(fi_r + SLOT_W'(1));
  assign sel_cell = cmd.cd_ctr ? ent_r[0] : ent_r[nb_idx];
  assign dsum     = {1'b0, pw_r} + {1'b0, pg_r};
  assign dnew     = dsum[48:15];
  assign rem_sh   = {rem_r[REM_W-2:0], (dcnt_r == '0) ? dn_r[0] : 1'b0};
  assign fp_lo    = dc_r[31:0] * q_r;
  assign fp_hi    = dc_r[DIFF_W-1:32] * q_r;
  assign fprod    = {2'b0, fp_lo} + {fp_hi, 32'b0};
  assign face2    = emp_r[fi_r ^ SLOT_W'(1)] ? {face_r, 1'b0} : {1'b0, face_r};
  assign dphi     = $signed({1'b0, ent_r[nb_idx].phi}) - $signed({1'b0, pc});
  assign term     = $signed({1'b0, face2}) * dphi;

  assign sts.tiny      = (sum_r < SUM_W'(TINY_DIFF));
  assign sts.div_last  = (dcnt_r == DCNT_W'(DIV_STEPS - 1));
  assign sts.face_last = (fi_r == SLOT_W'(NFACE - 1));

  always_ff @(posedge clk) begin
    if (cmd.latch) acc_r <= '0;
    if (cmd.cd_mul) begin
      pw_r <= sel_cell.white * white_r;
      pg_r <= sel_cell.grey * grey_r;
    end
    if (cmd.cd_fin) begin
      if (cmd.cd_ctr) begin
        dc_r <= dnew;
        fi_r <= '0;
      end else begin
        dn_r   <= dnew;
        sum_r  <= {1'b0, dc_r} + {1'b0, dnew};
        rem_r  <= {2'b0, dnew[DIFF_W-1:1]};
        q_r    <= '0;
        dcnt_r <= '0;
      end
    end
    if (cmd.div_step) begin
      if (rem_sh >= {1'b0, sum_r}) begin
        rem_r <= rem_sh - {1'b0, sum_r};
        q_r   <= {q_r[Q_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        q_r   <= {q_r[Q_W-2:0], 1'b0};
      end
      dcnt_r <= dcnt_r + DCNT_W'(1);
    end
    if (cmd.face_zero) face_r <= '0;
    if (cmd.face_mul)  face_r <= fprod[64:29];
    if (cmd.acc) begin
      acc_r <= acc_r + {{(ACC_W-55){term[54]}}, term};
      fi_r  <= nb_idx;
    end
  end

  // diffusion scaling, reaction and saturation
  logic [ACC_W-1:0]     acc_mag;
  logic                 dneg_r, pneg_r;
  logic [ACC_W-1:0]     ph_r;
  logic [63:0]          pl_r, dm_r, rmul;
  logic signed [17:0]   pc_s, one_m;
  logic signed [35:0]   pr_r, pr_abs;
  logic [33:0]          rm_r;
  logic signed [65:0]   dm_s, rm_s, total;
  logic signed [RATE_W-1:0] rate_r;

  assign acc_mag = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
  assign pc_s    = $signed({2'b0, pc});
  assign one_m   = 18'sd32768 - pc_s;
  assign pr_abs  = pr_r[35] ? -pr_r : pr_r;
  assign rmul    = pr_abs[31:0] * rho_r;
  assign dm_s    = dneg_r ? -$signed({2'b0, dm_r}) : $signed({2'b0, dm_r});
  assign rm_s    = pneg_r ? -$signed({32'b0, rm_r}) : $signed({32'b0, rm_r});
  assign total   = dm_s + rm_s;

  always_ff @(posedge clk) begin
    if (cmd.dif_a) begin
      dneg_r <= acc_r[ACC_W-1];
      ph_r   <= acc_mag[ACC_W-1:32] * ih2_r;
      pl_r   <= acc_mag[31:0] * ih2_r;
      pr_r   <= pc_s * one_m;
    end
    if (cmd.dif_b) begin
      dm_r   <= {1'b0, ph_r, 5'b0} + 64'(pl_r[63:27]);
      rm_r   <= rmul[63:30];
      pneg_r <= pr_r[35];
    end
    if (cmd.rate_zero) rate_r <= '0;
    if (cmd.rate_sum) begin
      if (total > 66'sd2147483647)       rate_r <= 32'sh7fffffff;
      else if (total < -66'sd2147483648) rate_r <= 32'sh80000000;
      else                               rate_r <= total[RATE_W-1:0];
    end
  end

  // euler update and output register
  logic [RATE_W-1:0]  rmag;
  logic [63:0]        umul;
  logic [22:0]        urm_r;
  logic signed [24:0] ubase, upd;

  assign rmag  = rate_r[RATE_W-1] ? RATE_W'(-rate_r) : RATE_W'(rate_r);
  assign umul  = rmag * dt_r;
  assign ubase = $signed({9'b0, pc});
  assign upd   = rate_r[RATE_W-1] ? ubase - $signed({2'b0, urm_r})
                                  : ubase + $signed({2'b0, urm_r});

  always_ff @(posedge clk) begin
    if (cmd.up_a) urm_r <= umul[63:41];
    if (cmd.out_load) begin
      out_rate <= rate_r;
      out_done <= last_r;
      if (upd < 25'sd0)            out_upd <= '0;
      else if (upd > 25'sd32768)   out_upd <= FIELD_W'(ONE_Q15);
      else                         out_upd <= upd[FIELD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign sts.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

### rtl/reaction_diffusion_stencil_update.sv
// ----------------------------------------------------------------------------
// reaction_diffusion_stencil_update
// Fisher-KPP 7-point stencil with explicit Euler step over one padded block.
// ----------------------------------------------------------------------------
// Cells arrive one word at a time in raster order, x fastest, with a one-cell
// halo ((BLOCK_EDGE+2)^3 words per block). Words in halo rows and columns and
// words before the third plane are stored and give no result. An interior cell
// produces its result when its +z neighbour arrives: the block then reads
// six entries from the two-plane store (one ram read port), runs the centre
// and six face diffusivities through one iterative divider (31 quotient bits
// per face), then the reaction and the Euler update. Faces with a diffusivity
// sum under the threshold skip the divider. A cell with no material gets a
// zero rate and skips the face passes. The result waits in an output
// register, so halo words keep flowing while it is not taken. The store needs
// no clearing after reset.
`default_nettype none
`include "assert_macros.svh"

module reaction_diffusion_stencil_update import rds_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  rds_in_if.sink                    in_ch,
  rds_out_if.source                 out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  cmd_t  cmd;
  sts_t  sts;
  cell_t in_cell;
  logic  in_ready;

  assign in_cell.phi   = in_ch.concentration;
  assign in_cell.white = in_ch.white_fraction;
  assign in_cell.grey  = in_ch.grey_fraction;
  assign in_ch.ready   = in_ready;

  rds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rds_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_cell   (in_cell),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_rate  (out_ch.rate_of_change),
    .out_upd   (out_ch.updated_concentration),
    .out_done  (out_ch.block_done)
  );

  // an interior word stalls the input while its result is computed
  `RDS_ASSERT_NEXT(a_busy_after_emit, in_ch.valid && in_ready && sts.emit, !in_ready)
  // the clamp keeps the density within one
  `RDS_ASSERT_NOW(a_upd_clamped, out_ch.valid,
                  out_ch.updated_concentration <= FIELD_W'(ONE_Q15))
  // a fresh result only follows a busy stretch
  `RDS_ASSERT_NOW(a_result_after_work, $rose(out_ch.valid), $past(!in_ready))

endmodule

`default_nettype wire
